>>> rtl/core/tgar_pkg.sv
// Shared types, register indexes and constants for the tile atlas rectangle pipeline.
`timescale 1ns / 1ps

package tgar_pkg;

	localparam int NUM_TILESETS_DEF = 4;
	localparam int ENTRY_REGS       = 4;
	localparam int MAX_MAP_CELLS    = 1024;

	localparam int ID_W       = 29;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 54;
	localparam int DIV_STEPS  = 4;

	localparam logic [CFG_IDX_W-1:0] REG_ENTRY0   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_W    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_MAP_H    = 3'd5;

	localparam logic [7:0] MAP_CELL_RESET = 8'd16;

	localparam logic [31:0] FLAG_H = 32'h8000_0000;
	localparam logic [31:0] FLAG_V = 32'h4000_0000;
	localparam logic [31:0] FLAG_D = 32'h2000_0000;

	localparam logic [2:0] ST_DRAW       = 3'd0;
	localparam logic [2:0] ST_EMPTY      = 3'd1;
	localparam logic [2:0] ST_NO_TILESET = 3'd2;
	localparam logic [2:0] ST_NOT_LOADED = 3'd3;
	localparam logic [2:0] ST_ZERO_COLS  = 3'd4;

	typedef struct packed {
		logic            loaded;
		logic [7:0]      th;
		logic [7:0]      tw;
		logic [7:0]      cols;
		logic [ID_W-1:0] first;
	} entry_t;

	typedef struct packed {
		logic [9:0]  cell_x;
		logic [9:0]  cell_y;
		logic [31:0] raw_tile_id;
	} cell_t;

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  tileset_index;
		logic [15:0] src_left;
		logic [36:0] src_top;
		logic [15:0] src_right;
		logic [36:0] src_bottom;
		logic [17:0] world_x;
		logic [17:0] world_y;
	} rect_t;

	// Item state while the local id is divided by the column count.
	typedef struct packed {
		logic [2:0]      status;
		logic [1:0]      tsi;
		logic [7:0]      cols;
		logic [7:0]      tw;
		logic [7:0]      th;
		logic [17:0]     world_x;
		logic [17:0]     world_y;
		logic [ID_W-1:0] num;
		logic [7:0]      rem;
	} work_t;

endpackage

>>> rtl/core/tgar_select.sv
// Front stages: flag stripping, tileset choice, status and local id.
`timescale 1ns / 1ps

module tgar_select #(
	parameter int N_ENTRY = tgar_pkg::ENTRY_REGS
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  tgar_pkg::entry_t    entry [N_ENTRY],
	input  logic [7:0]          map_w,
	input  logic [7:0]          map_h,
	input  logic                in_valid,
	input  tgar_pkg::cell_t     in_cell,
	output logic                out_valid,
	output tgar_pkg::work_t     out_work
);

	localparam logic [16:0] MAP_LIMIT = 17'(tgar_pkg::MAX_MAP_CELLS);
	localparam logic [31:0] FLAG_MASK = tgar_pkg::FLAG_H | tgar_pkg::FLAG_V | tgar_pkg::FLAG_D;

	logic                     valid_s1, valid_s2, valid_s3;
	logic                     empty_s1;
	logic [tgar_pkg::ID_W-1:0] id_s1;
	logic [N_ENTRY-1:0]       cand_s1;
	logic [17:0]              wx_s1, wy_s1;

	logic [31:0]              stripped;
	logic [N_ENTRY-1:0]       win;
	logic [N_ENTRY-1:0]       cand_c;

	logic [2:0]               status_s2;
	logic [1:0]               tsi_s2;
	logic [7:0]               cols_s2, tw_s2, th_s2;
	logic [tgar_pkg::ID_W-1:0] first_s2, id_s2;
	logic [17:0]              wx_s2, wy_s2;

	tgar_pkg::entry_t         sel;
	logic [1:0]               tsi_c;
	logic [2:0]               status_c;

	assign stripped = in_cell.raw_tile_id & ~FLAG_MASK;

	always_comb begin
		for (int i = 0; i < N_ENTRY; i++) begin
			cand_c[i] = (entry[i].first != '0) && (entry[i].first <= stripped[tgar_pkg::ID_W-1:0]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			empty_s1 <= (in_cell.raw_tile_id == '0)
				|| ({7'd0, in_cell.cell_x} >= MAP_LIMIT)
				|| ({7'd0, in_cell.cell_y} >= MAP_LIMIT);
			id_s1    <= stripped[tgar_pkg::ID_W-1:0];
			cand_s1  <= cand_c;
			wx_s1    <= 18'(in_cell.cell_x) * 18'(map_w);
			wy_s1    <= 18'(in_cell.cell_y) * 18'(map_h);
		end
	end

	// The pairwise first-id compares see only the registers, which the user
	// keeps static while items flow (unenforced); ties go to the lower index.
	always_comb begin
		for (int i = 0; i < N_ENTRY; i++) begin
			win[i] = cand_s1[i];
			for (int j = 0; j < N_ENTRY; j++) begin
				if (j < i) begin
					if (cand_s1[j] && (entry[j].first >= entry[i].first)) win[i] = 1'b0;
				end else if (j > i) begin
					if (cand_s1[j] && (entry[j].first > entry[i].first)) win[i] = 1'b0;
				end
			end
		end
	end

	always_comb begin
		sel   = '0;
		tsi_c = '0;
		for (int i = 0; i < N_ENTRY; i++) begin
			if (win[i]) begin
				sel   = sel | entry[i];
				tsi_c = tsi_c | 2'(i);
			end
		end
		if (empty_s1) begin
			status_c = tgar_pkg::ST_EMPTY;
		end else if (win == '0) begin
			status_c = tgar_pkg::ST_NO_TILESET;
		end else if (!sel.loaded) begin
			status_c = tgar_pkg::ST_NOT_LOADED;
		end else if (sel.cols == '0) begin
			status_c = tgar_pkg::ST_ZERO_COLS;
		end else begin
			status_c = tgar_pkg::ST_DRAW;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s2 <= status_c;
			tsi_s2    <= empty_s1 ? 2'd0 : tsi_c;
			cols_s2   <= sel.cols;
			tw_s2     <= sel.tw;
			th_s2     <= sel.th;
			first_s2  <= sel.first;
			id_s2     <= id_s1;
			wx_s2     <= wx_s1;
			wy_s2     <= wy_s1;

			out_work.status  <= status_s2;
			out_work.tsi     <= tsi_s2;
			out_work.cols    <= cols_s2;
			out_work.tw      <= tw_s2;
			out_work.th      <= th_s2;
			out_work.world_x <= wx_s2;
			out_work.world_y <= wy_s2;
			out_work.num     <= id_s2 - first_s2;
			out_work.rem     <= '0;
		end
	end

	assign out_valid = valid_s3;

endmodule

>>> rtl/core/tgar_div_stage.sv
// One stage of the restoring divider that splits the local id into row and column.
`timescale 1ns / 1ps

module tgar_div_stage #(
	parameter int STEPS = tgar_pkg::DIV_STEPS
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  tgar_pkg::work_t in_work,
	output logic            out_valid,
	output tgar_pkg::work_t out_work
);

	tgar_pkg::work_t w;
	logic            valid_s1;
	tgar_pkg::work_t work_s1;

	// Each step brings in the next dividend bit and shifts one quotient bit
	// into the bottom of num, so num holds the quotient after the last stage.
	always_comb begin
		logic [8:0] r9;
		w = in_work;
		for (int k = 0; k < STEPS; k++) begin
			r9    = {w.rem, w.num[tgar_pkg::ID_W-1]};
			w.num = {w.num[tgar_pkg::ID_W-2:0], 1'b0};
			if (r9 >= {1'b0, w.cols}) begin
				r9       = r9 - {1'b0, w.cols};
				w.num[0] = 1'b1;
			end
			w.rem = r9[7:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			work_s1 <= w;
		end
	end

	assign out_valid = valid_s1;
	assign out_work  = work_s1;

endmodule

>>> rtl/core/tgar_rect.sv
// Back stages: rectangle products and sums, output register and skid buffer.
`timescale 1ns / 1ps

module tgar_rect (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  tgar_pkg::work_t in_work,
	output logic            hold,
	output logic            out_valid,
	input  logic            out_stall,
	output tgar_pkg::rect_t out_data
);

	logic            en;
	logic            draw;

	logic            valid_s1;
	logic [2:0]      status_s1;
	logic [1:0]      tsi_s1;
	logic [15:0]     left_s1;
	logic [36:0]     top_s1;
	logic [7:0]      tw_s1, th_s1;
	logic [17:0]     wx_s1, wy_s1;

	tgar_pkg::rect_t nx;
	logic [16:0]     right_sum;
	logic [37:0]     bottom_sum;
	logic            draw_s1;

	logic            out_valid_q, skid_valid_q;
	tgar_pkg::rect_t out_q, skid_q;
	logic            pop;

	assign en   = !skid_valid_q;
	assign hold = skid_valid_q;
	assign draw = (in_work.status == tgar_pkg::ST_DRAW);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status_s1 <= in_work.status;
			tsi_s1    <= in_work.tsi;
			left_s1   <= draw ? 16'(in_work.rem) * 16'(in_work.tw) : '0;
			top_s1    <= draw ? 37'(in_work.num) * 37'(in_work.th) : '0;
			tw_s1     <= in_work.tw;
			th_s1     <= in_work.th;
			wx_s1     <= in_work.world_x;
			wy_s1     <= in_work.world_y;
		end
	end

	assign draw_s1    = (status_s1 == tgar_pkg::ST_DRAW);
	assign right_sum  = {1'b0, left_s1} + 17'(tw_s1);
	assign bottom_sum = {1'b0, top_s1} + 38'(th_s1);

	always_comb begin
		nx.status        = status_s1;
		nx.tileset_index = tsi_s1;
		nx.src_left      = left_s1;
		nx.src_top       = top_s1;
		nx.src_right     = draw_s1 ? right_sum[15:0] : '0;
		nx.src_bottom    = draw_s1 ? bottom_sum[36:0] : '0;
		nx.world_x       = wx_s1;
		nx.world_y       = wy_s1;
	end

	assign pop = out_valid_q && !out_stall;

	// A finished item that meets a stalled output waits in the skid register,
	// and the pipeline freezes until the skid drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				skid_valid_q <= 1'b0;
			end
		end else if (out_valid_q && !pop) begin
			skid_valid_q <= valid_s1;
		end else begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) begin
				out_q <= skid_q;
			end
		end else if (out_valid_q && !pop) begin
			skid_q <= nx;
		end else begin
			out_q <= nx;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

>>> rtl/core/tile_gid_atlas_rect.sv
// Top level of the tile id to atlas rectangle block: registers and pipeline.
`timescale 1ns / 1ps

// Takes one map cell per cycle while cell_stall is low, gives one rectangle transfer
// per cell, in order. Most of the pipeline depth is the restoring
// divider that splits the local id by the column count, four
// quotient bits per stage over eight stages, the last stage taking the one bit left;
// before it sit three stages for flag stripping, tileset choice and the local id,
// after it one stage of multipliers and the output register with its sums. When the
// output stalls, one finished result moves into a skid register and cell_stall rises
// the cycle after, so one more cell is taken while a result waits. Configuration
// writes take effect at once and are meant for times when no cell is in flight.

module tile_gid_atlas_rect #(
	parameter int NUM_TILESETS = tgar_pkg::NUM_TILESETS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [tgar_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tgar_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              cell_valid,
	output logic                              cell_stall,
	input  tgar_pkg::cell_t                   map_cell,
	output logic                              rect_valid,
	input  logic                              rect_stall,
	output tgar_pkg::rect_t                   rect
);

	localparam int N_ENTRY = (NUM_TILESETS < tgar_pkg::ENTRY_REGS) ?
		NUM_TILESETS : tgar_pkg::ENTRY_REGS;
	localparam int DIV_STAGES = (tgar_pkg::ID_W + tgar_pkg::DIV_STEPS - 1) / tgar_pkg::DIV_STEPS;

	tgar_pkg::entry_t entry_q [N_ENTRY];
	logic [7:0]       map_w_q, map_h_q;

	logic             hold, en;
	logic             valid_d [DIV_STAGES+1];
	tgar_pkg::work_t  work_d  [DIV_STAGES+1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < N_ENTRY; i++) begin
				entry_q[i] <= '0;
			end
			map_w_q <= tgar_pkg::MAP_CELL_RESET;
			map_h_q <= tgar_pkg::MAP_CELL_RESET;
		end else if (cfg_we) begin
			for (int i = 0; i < N_ENTRY; i++) begin
				if (cfg_index == tgar_pkg::CFG_IDX_W'(int'(tgar_pkg::REG_ENTRY0) + i)) begin
					entry_q[i] <= tgar_pkg::entry_t'(cfg_data);
				end
			end
			if (cfg_index == tgar_pkg::REG_MAP_W) begin
				map_w_q <= cfg_data[7:0];
			end
			if (cfg_index == tgar_pkg::REG_MAP_H) begin
				map_h_q <= cfg_data[7:0];
			end
		end
	end

	assign en         = !hold;
	assign cell_stall = hold;

	tgar_select #(
		.N_ENTRY (N_ENTRY)
	) u_select (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.entry     (entry_q),
		.map_w     (map_w_q),
		.map_h     (map_h_q),
		.in_valid  (cell_valid),
		.in_cell   (map_cell),
		.out_valid (valid_d[0]),
		.out_work  (work_d[0])
	);

	for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
		localparam int LEFT  = tgar_pkg::ID_W - k * tgar_pkg::DIV_STEPS;
		localparam int STEPS = (LEFT < tgar_pkg::DIV_STEPS) ? LEFT : tgar_pkg::DIV_STEPS;

		tgar_div_stage #(
			.STEPS (STEPS)
		) u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (en),
			.in_valid  (valid_d[k]),
			.in_work   (work_d[k]),
			.out_valid (valid_d[k+1]),
			.out_work  (work_d[k+1])
		);
	end

	tgar_rect u_rect (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (valid_d[DIV_STAGES]),
		.in_work   (work_d[DIV_STAGES]),
		.hold      (hold),
		.out_valid (rect_valid),
		.out_stall (rect_stall),
		.out_data  (rect)
	);

endmodule

>>> bench/tile_gid_atlas_rect_tb.sv
// Self-checking testbench for the tile id to atlas rectangle block.
`timescale 1ns / 1ps

module tile_gid_atlas_rect_tb;

	typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

	typedef struct {
		row_kind_t                       kind;
		logic [tgar_pkg::CFG_IDX_W-1:0]  idx;
		logic [tgar_pkg::CFG_DATA_W-1:0] data;
		tgar_pkg::cell_t                 item;
		bit                              typed;
		tgar_pkg::rect_t                 want;
	} stim_row_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            cfg_we = 1'b0;
	logic [tgar_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [tgar_pkg::CFG_DATA_W-1:0] cfg_data = '0;
	logic                            cell_valid = 1'b0;
	logic                            cell_stall;
	tgar_pkg::cell_t                 cell_in = '0;
	logic                            rect_valid;
	logic                            rect_stall = 1'b0;
	tgar_pkg::rect_t                 rect_out;

	// Shadow copy of the register file.
	tgar_pkg::entry_t ts_ent [tgar_pkg::ENTRY_REGS];
	logic [7:0]       map_w;
	logic [7:0]       map_h;

	tgar_pkg::rect_t rect_due_q [$];
	stim_row_t       stim_tab [$];
	int              rect_errs = 0;
	int              snd_idle = 34;
	int              rcv_idle = 52;
	bit              cfg_busy = 1'b0;

	always #5 clk = ~clk;

	// Ports in declaration order.
	tile_gid_atlas_rect u_dut (
		clk, arst_n, cfg_we, cfg_index, cfg_data,
		cell_valid, cell_stall, cell_in,
		rect_valid, rect_stall, rect_out
	);

	function automatic tgar_pkg::entry_t mk_entry(logic [tgar_pkg::ID_W-1:0] first,
			logic [7:0] cols, logic [7:0] tw, logic [7:0] th, logic loaded);
		tgar_pkg::entry_t e;
		e.first  = first;
		e.cols   = cols;
		e.tw     = tw;
		e.th     = th;
		e.loaded = loaded;
		return e;
	endfunction

	function automatic tgar_pkg::rect_t mk_rect(logic [2:0] st, logic [1:0] tsi,
			logic [15:0] l, logic [36:0] t, logic [15:0] r, logic [36:0] b,
			logic [17:0] wx, logic [17:0] wy);
		tgar_pkg::rect_t x;
		x.status        = st;
		x.tileset_index = tsi;
		x.src_left      = l;
		x.src_top       = t;
		x.src_right     = r;
		x.src_bottom    = b;
		x.world_x       = wx;
		x.world_y       = wy;
		return x;
	endfunction

	function automatic tgar_pkg::cell_t mk_cell(int x, int y, logic [31:0] raw);
		tgar_pkg::cell_t c;
		c.cell_x      = 10'(x);
		c.cell_y      = 10'(y);
		c.raw_tile_id = raw;
		return c;
	endfunction

	function automatic tgar_pkg::rect_t atlas_rect_of(tgar_pkg::cell_t c);
		tgar_pkg::rect_t           r;
		logic [31:0]               stripped;
		logic [tgar_pkg::ID_W-1:0] id;
		logic [tgar_pkg::ID_W-1:0] best_first;
		logic [tgar_pkg::ID_W-1:0] loc;
		logic [tgar_pkg::ID_W-1:0] quo;
		logic [tgar_pkg::ID_W-1:0] col;
		logic                      found;
		int                        best;
		tgar_pkg::entry_t          e;
		r = '0;
		r.world_x = 18'(c.cell_x) * 18'(map_w);
		r.world_y = 18'(c.cell_y) * 18'(map_h);
		found = 1'b0;
		best = 0;
		best_first = '0;
		if (c.raw_tile_id == 32'd0) begin
			r.status = tgar_pkg::ST_EMPTY;
		end else begin
			stripped = c.raw_tile_id & ~(tgar_pkg::FLAG_H | tgar_pkg::FLAG_V | tgar_pkg::FLAG_D);
			id = stripped[tgar_pkg::ID_W-1:0];
			// Strict compare keeps the lower index on a tie.
			for (int i = 0; i < tgar_pkg::NUM_TILESETS_DEF; i++) begin
				if (ts_ent[i].first != '0 && ts_ent[i].first <= id &&
						(!found || ts_ent[i].first > best_first)) begin
					found = 1'b1;
					best_first = ts_ent[i].first;
					best = i;
				end
			end
			if (!found) begin
				r.status = tgar_pkg::ST_NO_TILESET;
			end else begin
				e = ts_ent[best];
				r.tileset_index = 2'(best);
				if (!e.loaded) begin
					r.status = tgar_pkg::ST_NOT_LOADED;
				end else if (e.cols == 8'd0) begin
					r.status = tgar_pkg::ST_ZERO_COLS;
				end else begin
					r.status = tgar_pkg::ST_DRAW;
					loc = id - best_first;
					quo = loc / tgar_pkg::ID_W'(e.cols);
					col = loc % tgar_pkg::ID_W'(e.cols);
					r.src_left   = 16'(col) * 16'(e.tw);
					r.src_top    = 37'(quo) * 37'(e.th);
					r.src_right  = r.src_left + 16'(e.tw);
					r.src_bottom = r.src_top + 37'(e.th);
				end
			end
		end
		return r;
	endfunction

	function automatic logic [31:0] rand_raw();
		logic [2:0]       fl;
		tgar_pkg::entry_t e;
		int               r;
		fl = 3'($urandom_range(7));
		r = $urandom_range(15);
		e = ts_ent[2'($urandom_range(tgar_pkg::ENTRY_REGS - 1))];
		case (r)
			0: return 32'd0;
			1: return $urandom();
			2: return {fl, 29'd0};
			3: return {fl, e.first - 29'd1};
			default: return {fl, e.first + 29'($urandom_range(int'(e.cols) * 6 + 3))};
		endcase
	endfunction

	// Writes are only issued once every transfer in flight has come back.
	task automatic reg_write(input logic [tgar_pkg::CFG_IDX_W-1:0] idx,
			input logic [tgar_pkg::CFG_DATA_W-1:0] data);
		if (!cfg_busy) begin
			cell_valid <= 1'b0;
			while (rect_due_q.size() != 0)
				@(posedge clk);
			cfg_busy = 1'b1;
		end
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		if (idx < tgar_pkg::ENTRY_REGS)
			ts_ent[idx[1:0]] = data;
		else if (idx == tgar_pkg::REG_MAP_W)
			map_w = data[7:0];
		else if (idx == tgar_pkg::REG_MAP_H)
			map_h = data[7:0];
		@(posedge clk);
	endtask

	task automatic send_cell(input tgar_pkg::cell_t c, input bit typed,
			input tgar_pkg::rect_t want);
		if (cfg_busy) begin
			cfg_we <= 1'b0;
			cfg_busy = 1'b0;
		end
		while ($urandom_range(99) < snd_idle) begin
			cell_valid <= 1'b0;
			@(posedge clk);
		end
		cell_valid <= 1'b1;
		cell_in <= c;
		@(posedge clk);
		while (cell_stall)
			@(posedge clk);
		rect_due_q.insert(rect_due_q.size(), typed ? want : atlas_rect_of(c));
	endtask

	task automatic rand_settings();
		tgar_pkg::entry_t ents [tgar_pkg::ENTRY_REGS];
		int               r;
		for (int i = 0; i < tgar_pkg::ENTRY_REGS; i++) begin
			r = $urandom_range(9);
			if (r < 2)
				ents[i].first = '0;
			else if (r == 2 && i > 0)
				ents[i].first = ents[i-1].first;
			else if (r == 3)
				ents[i].first = 29'h1FFF_FFFF - 29'($urandom_range(40));
			else if (r == 4)
				ents[i].first = 29'($urandom());
			else
				ents[i].first = 29'($urandom_range(300, 1));
			r = $urandom_range(9);
			ents[i].cols = (r == 0) ? 8'd0 : (r == 1) ? 8'd255 : 8'($urandom_range(16, 1));
			ents[i].tw = 8'($urandom_range(255));
			ents[i].th = 8'($urandom_range(255));
			ents[i].loaded = ($urandom_range(7) != 0);
		end
		for (int i = 0; i < tgar_pkg::ENTRY_REGS; i++)
			reg_write(tgar_pkg::REG_ENTRY0 + tgar_pkg::CFG_IDX_W'(i), ents[i]);
		r = $urandom_range(7);
		reg_write(tgar_pkg::REG_MAP_W, tgar_pkg::CFG_DATA_W'((r == 0) ? 0 :
			(r == 1) ? 255 : $urandom_range(255, 1)));
		r = $urandom_range(7);
		reg_write(tgar_pkg::REG_MAP_H, tgar_pkg::CFG_DATA_W'((r == 0) ? 0 :
			(r == 1) ? 255 : $urandom_range(255, 1)));
	endtask

	task automatic add_cfg(input logic [tgar_pkg::CFG_IDX_W-1:0] idx,
			input logic [tgar_pkg::CFG_DATA_W-1:0] data);
		stim_row_t row;
		row.kind = ROW_CFG;
		row.idx = idx;
		row.data = data;
		row.item = '0;
		row.typed = 1'b0;
		row.want = '0;
		stim_tab.insert(stim_tab.size(), row);
	endtask

	task automatic add_cell(input tgar_pkg::cell_t c, input bit typed,
			input tgar_pkg::rect_t want);
		stim_row_t row;
		row.kind = ROW_CELL;
		row.idx = '0;
		row.data = '0;
		row.item = c;
		row.typed = typed;
		row.want = want;
		stim_tab.insert(stim_tab.size(), row);
	endtask

	task automatic build_directed();
		// Reset settings: no tileset in use, 16 pixel map cells.
		add_cell(mk_cell(0, 0, 32'd0), 1, mk_rect(tgar_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 0, 0));
		add_cell(mk_cell(1023, 1023, 32'd0), 1,
			mk_rect(tgar_pkg::ST_EMPTY, 0, 0, 0, 0, 0, 18'd16368, 18'd16368));
		add_cell(mk_cell(5, 7, 32'hFFFF_FFFF), 1,
			mk_rect(tgar_pkg::ST_NO_TILESET, 0, 0, 0, 0, 0, 18'd80, 18'd112));
		// Only flip flags set strips down to id zero.
		add_cell(mk_cell(1023, 0, tgar_pkg::FLAG_H | tgar_pkg::FLAG_V | tgar_pkg::FLAG_D), 1,
			mk_rect(tgar_pkg::ST_NO_TILESET, 0, 0, 0, 0, 0, 18'd16368, 18'd0));

		// Entries one and three tie on first id; entry two has no image.
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd0, mk_entry(29'd1, 8'd8, 8'd16, 8'd16, 1'b1));
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd1, mk_entry(29'd100, 8'd0, 8'd8, 8'd8, 1'b1));
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd2, mk_entry(29'd200, 8'd4, 8'd32, 8'd32, 1'b0));
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd3, mk_entry(29'd100, 8'd10, 8'd4, 8'd4, 1'b1));
		add_cfg(tgar_pkg::REG_MAP_W, tgar_pkg::CFG_DATA_W'(255));
		add_cfg(tgar_pkg::REG_MAP_H, tgar_pkg::CFG_DATA_W'(1));
		add_cell(mk_cell(1023, 1023, 32'd1), 1,
			mk_rect(tgar_pkg::ST_DRAW, 0, 0, 0, 16'd16, 37'd16, 18'd260865, 18'd1023));
		add_cell(mk_cell(2, 3, 32'd150), 1,
			mk_rect(tgar_pkg::ST_ZERO_COLS, 2'd1, 0, 0, 0, 0, 18'd510, 18'd3));
		add_cell(mk_cell(0, 0, 32'd250 | tgar_pkg::FLAG_V), 1,
			mk_rect(tgar_pkg::ST_NOT_LOADED, 2'd2, 0, 0, 0, 0, 0, 0));
		add_cell(mk_cell(10, 10, 32'd99 | tgar_pkg::FLAG_H), 0, '0);
		add_cell(mk_cell(1, 1, 32'h1FFF_FFFF), 0, '0);
		add_cell(mk_cell(4, 1000, 32'hE000_0064), 0, '0);
		add_cell(mk_cell(7, 7, 32'h0000_0063), 0, '0);

		// Largest first id, widest tiles, zero map width, and writes past the last register.
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd0,
			mk_entry(29'h1FFF_FFFF, 8'd255, 8'd255, 8'd255, 1'b1));
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd1, '0);
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd2, mk_entry(29'd1, 8'd1, 8'd255, 8'd255, 1'b1));
		add_cfg(tgar_pkg::REG_ENTRY0 + 3'd3,
			mk_entry(29'h1000_0000, 8'd255, 8'd255, 8'd255, 1'b1));
		add_cfg(tgar_pkg::REG_MAP_W, '0);
		add_cfg(tgar_pkg::REG_MAP_H, tgar_pkg::CFG_DATA_W'(255));
		add_cfg(tgar_pkg::REG_MAP_H + 3'd1, '1);
		add_cfg(tgar_pkg::REG_MAP_H + 3'd2, '1);
		add_cell(mk_cell(1023, 1023, 32'hFFFF_FFFF), 1,
			mk_rect(tgar_pkg::ST_DRAW, 0, 0, 0, 16'd255, 37'd255, 18'd0, 18'd260865));
		add_cell(mk_cell(3, 3, 32'h0FFF_FFFF), 0, '0);
		add_cell(mk_cell(0, 1023, 32'd1), 0, '0);
		add_cell(mk_cell(512, 1, 32'h1000_00FE), 0, '0);
		add_cell(mk_cell(0, 0, 32'h5FFF_FFFE), 0, '0);
	endtask

	// Output side: random stall and in-order compare.
	always @(posedge clk) begin
		tgar_pkg::rect_t want;
		if (arst_n && rect_valid && !rect_stall) begin
			if (rect_due_q.size() == 0) begin
				rect_errs++;
				if (rect_errs <= 10)
					$display("unexpected rect transfer: %p", rect_out);
			end else begin
				want = rect_due_q.pop_front();
				if (rect_out.status !== want.status ||
						rect_out.tileset_index !== want.tileset_index ||
						rect_out.src_left !== want.src_left ||
						rect_out.src_top !== want.src_top ||
						rect_out.src_right !== want.src_right ||
						rect_out.src_bottom !== want.src_bottom ||
						rect_out.world_x !== want.world_x ||
						rect_out.world_y !== want.world_y) begin
					rect_errs++;
					if (rect_errs <= 10)
						$display("rect mismatch at %0t: expected %p, got %p",
							$realtime, want, rect_out);
				end
			end
		end
		rect_stall <= ($urandom_range(99) < rcv_idle);
	end

	initial begin
		for (int i = 0; i < tgar_pkg::ENTRY_REGS; i++)
			ts_ent[i] = '0;
		map_w = tgar_pkg::MAP_CELL_RESET;
		map_h = tgar_pkg::MAP_CELL_RESET;
		build_directed();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_tab[i]) begin
			if (stim_tab[i].kind == ROW_CFG)
				reg_write(stim_tab[i].idx, stim_tab[i].data);
			else
				send_cell(stim_tab[i].item, stim_tab[i].typed, stim_tab[i].want);
		end

		for (int mode = 0; mode < 3; mode++) begin
			snd_idle = (mode == 0) ? 34 : (mode == 1) ? 52 : 0;
			rcv_idle = (mode == 0) ? 52 : (mode == 1) ? 34 : 0;
			repeat (3) begin
				rand_settings();
				repeat (210)
					send_cell(mk_cell($urandom_range(1023), $urandom_range(1023), rand_raw()),
						0, '0);
			end
		end
		if (cfg_busy)
			cfg_we <= 1'b0;
		cell_valid <= 1'b0;

		while (rect_due_q.size() != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (rect_errs == 0 && rect_due_q.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule
